FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_PROP(lbl, !(cond), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, codes and types of the multichannel sample averager.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

  localparam int CODE_W       = 12;
  localparam int RAW_W        = 16;
  localparam int GAIN_W       = 24;
  localparam int RD_W         = 16;
  localparam int Q_FRAC       = 16;
  localparam int LANES        = 8;
  localparam int NUM_OFFS     = 8;
  localparam int CH_W         = 4;
  localparam int KIND_W       = 2;

  // window length in columns per channel
  localparam int WINDOW_DEPTH = 8;
  localparam int COL_W        = $clog2(WINDOW_DEPTH);
  localparam int ROWS         = 2 * WINDOW_DEPTH;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int SUM_W        = CODE_W + COL_W;
  localparam int PROD_W       = CODE_W + GAIN_W;

  // reciprocal of the window depth, rounded up; exact floor for any window sum
  localparam int DIV_SH       = SUM_W + COL_W;
  localparam int DIV_M_W      = SUM_W + 2;
  localparam int DIVP_W       = SUM_W + DIV_M_W;

  localparam logic [COL_W-1:0]   LAST_COL = COL_W'(WINDOW_DEPTH - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [DIV_M_W-1:0] DIV_M    =
    DIV_M_W'(((1 << DIV_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LIM  = 3'd4;
  localparam logic [RD_W-1:0]      BLANK_LIM_RST  = 16'd220;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_POS_VOLT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEG_VOLT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AMP_HI   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_AMP_LO   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_CAL_END,
    ST_ACC,
    ST_ACC_END,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SUB,
    ST_MUL,
    ST_OUT
  } msa_state_e;

  // one memory row: one column of one bank, eight channel codes
  typedef logic [LANES-1:0][CODE_W-1:0] msa_row_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] quot;
  } msa_div_res_t;

endpackage

`default_nettype wire

FILE: design/msa_ram.sv
// ----------------------------------------------------------------------------
// msa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/msa_div.sv
// ----------------------------------------------------------------------------
// msa_div
// Divides the window sum by the window depth with a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msa_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [msa_pkg::SUM_W-1:0] dividend_i,
  output msa_pkg::msa_div_res_t          res_o
);

  logic                       done_q, done_d;
  logic [msa_pkg::DIVP_W-1:0] prod_q, prod_d;

  // quotient is ready in the cycle after start
  assign done_d = start_i;
  assign prod_d = msa_pkg::DIVP_W'(dividend_i) * msa_pkg::DIVP_W'(msa_pkg::DIV_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
  end

  assign res_o = {done_q, prod_q[msa_pkg::DIV_SH +: msa_pkg::CODE_W]};

  `ASSERT_PROP(a_done_follows, start_i |=> done_q, "divider result not flagged")
  `ASSERT_NEVER(a_start_done, start_i && done_q, "divider restarted on its result")
  `ASSERT_PROP(a_done_pulse, done_q |=> !done_q, "done held longer than one cycle")

endmodule

`default_nettype wire

FILE: design/multichannel_sample_averager.sv
// ----------------------------------------------------------------------------
// multichannel_sample_averager
// Sixteen-channel windowed sample store with averaged, scaled readings.
// ----------------------------------------------------------------------------
// A sample round is written into the store as one memory row in the cycle it
// is accepted. With output disabled it then scans all 2*WINDOW_DEPTH rows of
// the store, one read a cycle, to refresh the current offsets before the next
// beat is taken; otherwise the next beat is taken in the following cycle. A
// query reads the channel's WINDOW_DEPTH rows, divides the sum by the depth
// with a registered reciprocal multiply and then subtracts, multiplies and
// scales before the next beat is taken. Rows never written read as zero
// through per-row valid flags, so there is no clearing pass after reset. A
// finished result waits in the output register while the next beat is taken;
// a second finished query then holds the input until the first result is
// taken.
`default_nettype none

`include "assert_macros.svh"

module multichannel_sample_averager (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [msa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           action_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_0_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_1_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_2_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_3_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_4_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_5_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_6_i,
  input  wire logic [msa_pkg::RAW_W-1:0]      sample_7_i,
  input  wire logic                           output_disabled_i,
  input  wire logic [msa_pkg::CH_W-1:0]       channel_i,
  input  wire logic [msa_pkg::KIND_W-1:0]     measure_kind_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [msa_pkg::RD_W-1:0]       reading_o,
  output logic      [msa_pkg::CODE_W-1:0]     offset_code_o,
  output logic                                reading_valid_o
);

  // configuration registers
  logic [msa_pkg::CODE_W-1:0] zero_code_q;
  logic [msa_pkg::CODE_W-1:0] neg_offset_q;
  logic [msa_pkg::GAIN_W-1:0] volt_gain_q;
  logic [msa_pkg::GAIN_W-1:0] amp_gain_q;
  logic [msa_pkg::RD_W-1:0]   blank_lim_q;

  // control state
  msa_pkg::msa_state_e        state_q, state_d;
  logic [msa_pkg::COL_W-1:0]  col_q;
  logic                       bank_q;
  logic [msa_pkg::ROWS-1:0]   row_vld_q;
  logic [msa_pkg::ROW_W-1:0]  rd_cnt_q;
  logic                       rd_vld_q;
  logic                       rd_half_q;
  logic                       rd_rowv_q;
  logic                       out_valid_q;

  // payload
  logic [msa_pkg::CODE_W-1:0] offs_q [msa_pkg::NUM_OFFS];
  logic [msa_pkg::CH_W-1:0]   ch_q;
  logic [msa_pkg::KIND_W-1:0] kind_q;
  logic [msa_pkg::SUM_W-1:0]  sum_q;
  logic [msa_pkg::CODE_W-1:0] avg_q;
  logic [msa_pkg::CODE_W-1:0] code_q;
  logic [msa_pkg::GAIN_W-1:0] gain_q;
  logic [msa_pkg::PROD_W-1:0] prod_q;
  logic [msa_pkg::RD_W-1:0]   reading_q;
  logic [msa_pkg::CODE_W-1:0] ocode_q;
  logic                       rvalid_q;

  // datapath wires
  logic                       in_acc, smp_acc, cal_start, out_free;
  logic                       rd_en, div_start, out_load;
  logic [msa_pkg::ROW_W-1:0]  rd_addr, wr_addr;
  logic [msa_pkg::RAW_W-1:0]  raw [msa_pkg::LANES];
  msa_pkg::msa_row_t          wr_row, ram_rdata, rd_row;
  logic [msa_pkg::CODE_W-1:0] rd_lane;
  logic                       cal_abs, acc_abs;
  logic [msa_pkg::CODE_W-1:0] off_sel, sub_val;
  logic [msa_pkg::GAIN_W-1:0] gain_sel;
  logic [msa_pkg::RD_W-1:0]   rd_scaled, rd_final;
  logic                       rd_valid_final;
  msa_pkg::msa_div_res_t      div_res;

  assign in_ready_o = (state_q == msa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign smp_acc    = in_acc && (action_i == msa_pkg::ACT_SAMPLE);
  assign cal_start  = smp_acc && output_disabled_i;
  assign out_free   = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_code_q  <= '0;
      neg_offset_q <= '0;
      volt_gain_q  <= '0;
      amp_gain_q   <= '0;
      blank_lim_q  <= msa_pkg::BLANK_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msa_pkg::CFG_ZERO_CODE:  zero_code_q  <= cfg_wdata_i[msa_pkg::CODE_W-1:0];
        msa_pkg::CFG_NEG_OFFSET: neg_offset_q <= cfg_wdata_i[msa_pkg::CODE_W-1:0];
        msa_pkg::CFG_VOLT_GAIN:  volt_gain_q  <= cfg_wdata_i[msa_pkg::GAIN_W-1:0];
        msa_pkg::CFG_AMP_GAIN:   amp_gain_q   <= cfg_wdata_i[msa_pkg::GAIN_W-1:0];
        msa_pkg::CFG_BLANK_LIM:  blank_lim_q  <= cfg_wdata_i[msa_pkg::RD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- write side
  assign raw[0] = sample_0_i;
  assign raw[1] = sample_1_i;
  assign raw[2] = sample_2_i;
  assign raw[3] = sample_3_i;
  assign raw[4] = sample_4_i;
  assign raw[5] = sample_5_i;
  assign raw[6] = sample_6_i;
  assign raw[7] = sample_7_i;

  // drop the four low bits, raise to zero_code
  always_comb begin
    for (int j = 0; j < msa_pkg::LANES; j++) begin
      wr_row[j] = (raw[j][msa_pkg::RAW_W-1:4] < zero_code_q) ?
                  zero_code_q : raw[j][msa_pkg::RAW_W-1:4];
    end
  end

  // row = {column, half}; half 1 holds channels 4..7 and 12..15 (upper bank)
  assign wr_addr = {col_q, ~bank_q};

  msa_ram #(
    .WIDTH ($bits(msa_pkg::msa_row_t)),
    .DEPTH (msa_pkg::ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (wr_addr),
    .wdata_i (wr_row),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      bank_q    <= 1'b0;
      row_vld_q <= '0;
    end else if (smp_acc) begin
      row_vld_q[wr_addr] <= 1'b1;
      bank_q             <= ~bank_q;
      if (!bank_q) begin
        col_q <= (col_q == msa_pkg::LAST_COL) ? '0 : col_q + 1'b1;
      end
    end
  end

  // ----------------------------------------------------------- read side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_half_q <= 1'b0;
      rd_rowv_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      rd_half_q <= rd_addr[0];
      rd_rowv_q <= row_vld_q[rd_addr];
      if (in_acc) begin
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  assign rd_row  = rd_rowv_q ? ram_rdata : '0;
  assign rd_lane = rd_row[{ch_q[3], ch_q[1:0]}];
  assign cal_abs = rd_vld_q &&
                   (state_q == msa_pkg::ST_CAL || state_q == msa_pkg::ST_CAL_END);
  assign acc_abs = rd_vld_q &&
                   (state_q == msa_pkg::ST_ACC || state_q == msa_pkg::ST_ACC_END);

  // offset k follows channel 2k+1: half k[1], lane {k[2], k[0], 1}
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < msa_pkg::NUM_OFFS; k++) begin
        offs_q[k] <= '0;
      end
    end else if (cal_start) begin
      for (int k = 0; k < msa_pkg::NUM_OFFS; k++) begin
        offs_q[k] <= '0;
      end
    end else if (cal_abs) begin
      for (int k = 0; k < msa_pkg::NUM_OFFS; k++) begin
        if (rd_half_q == 1'((k >> 1) & 1) &&
            rd_row[3'(((k >> 2) << 2) | ((k & 1) << 1) | 1)] > offs_q[k]) begin
          offs_q[k] <= rd_row[3'(((k >> 2) << 2) | ((k & 1) << 1) | 1)];
        end
      end
    end
  end

  // ----------------------------------------------------------- query path
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= channel_i;
      kind_q <= measure_kind_i;
      sum_q  <= '0;
    end else if (acc_abs) begin
      sum_q <= sum_q + msa_pkg::SUM_W'(rd_lane);
    end
  end

  msa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .res_o      (div_res)
  );

  always_comb begin
    case (kind_q)
      msa_pkg::KIND_POS_VOLT: begin
        off_sel  = zero_code_q;
        gain_sel = volt_gain_q;
      end
      msa_pkg::KIND_NEG_VOLT: begin
        off_sel  = neg_offset_q;
        gain_sel = volt_gain_q;
      end
      msa_pkg::KIND_AMP_HI: begin
        // channel 0 wraps to offset 7
        off_sel  = offs_q[3'((ch_q - 1'b1) >> 1)];
        gain_sel = amp_gain_q;
      end
      default: begin
        off_sel  = '0;
        gain_sel = amp_gain_q;
      end
    endcase
  end

  assign sub_val = (avg_q < off_sel) ? '0 : avg_q - off_sel;

  always_ff @(posedge clk_i) begin
    if (div_res.done) begin
      avg_q <= div_res.quot;
    end
    if (state_q == msa_pkg::ST_SUB) begin
      code_q <= sub_val;
      gain_q <= gain_sel;
    end
    if (state_q == msa_pkg::ST_MUL) begin
      prod_q <= msa_pkg::PROD_W'(code_q) * msa_pkg::PROD_W'(gain_q);
    end
  end

  // drop Q16 fraction, saturate, blank small negatives, zero and void AMP_LO
  always_comb begin
    rd_scaled = (|prod_q[msa_pkg::PROD_W-1:msa_pkg::Q_FRAC+msa_pkg::RD_W]) ?
                '1 : prod_q[msa_pkg::Q_FRAC+msa_pkg::RD_W-1:msa_pkg::Q_FRAC];
    rd_final       = rd_scaled;
    rd_valid_final = 1'b1;
    case (kind_q)
      msa_pkg::KIND_NEG_VOLT: begin
        if (rd_scaled < blank_lim_q) begin
          rd_final = '0;
        end
      end
      msa_pkg::KIND_AMP_LO: begin
        rd_final       = '0;
        rd_valid_final = 1'b0;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      reading_q <= rd_final;
      ocode_q   <= code_q;
      rvalid_q  <= rd_valid_final;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reading_o       = reading_q;
  assign offset_code_o   = ocode_q;
  assign reading_valid_o = rvalid_q;

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      msa_pkg::ST_IDLE: begin
        if (in_acc && action_i == msa_pkg::ACT_QUERY) begin
          state_d = msa_pkg::ST_ACC;
        end else if (cal_start) begin
          state_d = msa_pkg::ST_CAL;
        end
      end
      msa_pkg::ST_CAL: begin
        if (rd_cnt_q == msa_pkg::LAST_ROW) begin
          state_d = msa_pkg::ST_CAL_END;
        end
      end
      msa_pkg::ST_CAL_END: state_d = msa_pkg::ST_IDLE;
      msa_pkg::ST_ACC: begin
        if (rd_cnt_q[msa_pkg::COL_W-1:0] == msa_pkg::LAST_COL) begin
          state_d = msa_pkg::ST_ACC_END;
        end
      end
      msa_pkg::ST_ACC_END:   state_d = msa_pkg::ST_DIV_START;
      msa_pkg::ST_DIV_START: state_d = msa_pkg::ST_DIV_WAIT;
      msa_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_d = msa_pkg::ST_SUB;
        end
      end
      msa_pkg::ST_SUB: state_d = msa_pkg::ST_MUL;
      msa_pkg::ST_MUL: state_d = msa_pkg::ST_OUT;
      msa_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = msa_pkg::ST_IDLE;
        end
      end
      default: state_d = msa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = rd_cnt_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      msa_pkg::ST_CAL: begin
        rd_en = 1'b1;
      end
      msa_pkg::ST_ACC: begin
        rd_en   = 1'b1;
        rd_addr = {rd_cnt_q[msa_pkg::COL_W-1:0], ch_q[2]};
      end
      msa_pkg::ST_DIV_START: div_start = 1'b1;
      msa_pkg::ST_OUT:       out_load  = out_free;
      default: ;
    endcase
  end

  `ASSERT_PROP(a_idle_no_read, in_ready_o |-> !rd_vld_q, "read data pending while idle")
  `ASSERT_PROP(a_bank_toggle, smp_acc |=> (bank_q != $past(bank_q)), "bank did not toggle")
  `ASSERT_NEVER(a_col_range, col_q > msa_pkg::LAST_COL, "column pointer past window")
  `ASSERT_PROP(a_out_load, out_load |=> out_valid_o, "finished result not presented")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel sample averager. Sample rounds and
// channel queries go in through a valid/ready driver with random gaps. A
// clocked monitor with random stalls checks every reading against an in-bench
// copy of the window store, the calibrated current offsets and the scaling.
// ----------------------------------------------------------------------------

module tb;
  import msa_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int LATENCY_PAD    = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_BEATS    = 250;
  localparam int LONG_HOLD      = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic                        act;
    logic [LANES-1:0][RAW_W-1:0] smp;
    logic                        dis;
    logic [CH_W-1:0]             ch;
    logic [KIND_W-1:0]           kind;
  } beat_t;

  typedef struct packed {
    logic [RD_W-1:0]   reading;
    logic [CODE_W-1:0] code;
    logic              valid;
  } reading_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  out_ready_i = 1'b0;
  beat_t                 cur_beat    = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [RD_W-1:0]       reading_o;
  logic [CODE_W-1:0]     offset_code_o;
  logic                  reading_valid_o;

  // mirror of the block's registers and state
  logic [CODE_W-1:0] zero_code_r  = '0;
  logic [CODE_W-1:0] neg_offset_r = '0;
  logic [GAIN_W-1:0] volt_gain_r  = '0;
  logic [GAIN_W-1:0] amp_gain_r   = '0;
  logic [RD_W-1:0]   blank_lim_r  = BLANK_LIM_RST;
  logic [CODE_W-1:0] win_store [16][WINDOW_DEPTH] = '{default: '0};
  logic [CODE_W-1:0] amp_offs [NUM_OFFS] = '{default: '0};
  int                col_ptr = 0;
  bit                bank_lo = 1'b0;

  beat_t    pending_beats[$];
  reading_t reading_q[$];
  reading_t want;
  int       lane_lvl [LANES];
  int       errors       = 0;
  int       n_results    = 0;
  int       send_wait    = 0;
  int       recv_wait    = 0;
  bit       send_calm    = 1'b0;
  bit       recv_calm    = 1'b1;
  int       quiet_cycles = 0;

  multichannel_sample_averager i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (cur_beat.act),
    .sample_0_i       (cur_beat.smp[0]),
    .sample_1_i       (cur_beat.smp[1]),
    .sample_2_i       (cur_beat.smp[2]),
    .sample_3_i       (cur_beat.smp[3]),
    .sample_4_i       (cur_beat.smp[4]),
    .sample_5_i       (cur_beat.smp[5]),
    .sample_6_i       (cur_beat.smp[6]),
    .sample_7_i       (cur_beat.smp[7]),
    .output_disabled_i(cur_beat.dis),
    .channel_i        (cur_beat.ch),
    .measure_kind_i   (cur_beat.kind),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reading_o        (reading_o),
    .offset_code_o    (offset_code_o),
    .reading_valid_o  (reading_valid_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------- store and reading prediction ----------------

  function automatic logic [CODE_W-1:0] clip_raw(logic [RAW_W-1:0] raw);
    logic [CODE_W-1:0] c;
    c = raw[RAW_W-1:4];
    return (c < zero_code_r) ? zero_code_r : c;
  endfunction

  function automatic logic [CODE_W-1:0] window_max(int ch);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++)
      if (win_store[ch][i] > m) m = win_store[ch][i];
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] window_avg(int ch);
    int sum;
    sum = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) sum += win_store[ch][i];
    return CODE_W'(sum / WINDOW_DEPTH);
  endfunction

  function automatic logic [CODE_W-1:0] sub_floor(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
    return (a < b) ? '0 : a - b;
  endfunction

  function automatic logic [RD_W-1:0] scale_code(logic [CODE_W-1:0] code,
                                                 logic [GAIN_W-1:0] gain);
    logic [PROD_W-1:0] prod;
    prod = code * gain;
    prod = prod >> Q_FRAC;
    return (prod > PROD_W'(16'hFFFF)) ? 16'hFFFF : prod[RD_W-1:0];
  endfunction

  function automatic void store_round(beat_t b);
    int base;
    base = bank_lo ? 0 : 4;
    for (int i = 0; i < 4; i++) begin
      win_store[base + i][col_ptr]     = clip_raw(b.smp[i]);
      win_store[base + 8 + i][col_ptr] = clip_raw(b.smp[i + 4]);
    end
    if (!bank_lo) col_ptr = (col_ptr + 1) % WINDOW_DEPTH;
    bank_lo = !bank_lo;
    // offset calibration from the odd channels while output is off
    if (b.dis)
      for (int k = 0; k < NUM_OFFS; k++) amp_offs[k] = window_max(2 * k + 1);
  endfunction

  function automatic reading_t predict_reading(beat_t b);
    reading_t          r;
    logic [CODE_W-1:0] avg;
    logic [CH_W-1:0]   prev_ch;
    avg       = window_avg(b.ch);
    r.reading = '0;
    r.valid   = 1'b1;
    case (b.kind)
      KIND_POS_VOLT: begin
        r.code    = sub_floor(avg, zero_code_r);
        r.reading = scale_code(r.code, volt_gain_r);
      end
      KIND_NEG_VOLT: begin
        r.code    = sub_floor(avg, neg_offset_r);
        r.reading = scale_code(r.code, volt_gain_r);
        if (r.reading < blank_lim_r) r.reading = '0;
      end
      KIND_AMP_HI: begin
        // channel 0 wraps around to the last offset
        prev_ch   = b.ch - 1'b1;
        r.code    = sub_floor(avg, amp_offs[prev_ch[CH_W-1:1]]);
        r.reading = scale_code(r.code, amp_gain_r);
      end
      default: begin
        r.code  = avg;
        r.valid = 1'b0;
      end
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [RAW_W-1:0] rand_raw(int lane);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = int'($urandom_range(0, 65535));
      default: v = lane_lvl[lane] + int'($urandom_range(0, 2047)) - 1024;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RAW_W'(v);
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b.act = ($urandom_range(0, 9) < 4) ? ACT_QUERY : ACT_SAMPLE;
    for (int i = 0; i < LANES; i++) b.smp[i] = rand_raw(i);
    b.dis  = ($urandom_range(0, 2) == 0);
    b.ch   = CH_W'($urandom_range(0, 15));
    b.kind = KIND_W'($urandom_range(0, 3));
    return b;
  endfunction

  function automatic beat_t make_round(logic [RAW_W-1:0] v, logic dis);
    beat_t b;
    b     = rand_beat();
    b.act = ACT_SAMPLE;
    b.dis = dis;
    for (int i = 0; i < LANES; i++) b.smp[i] = v;
    return b;
  endfunction

  function automatic beat_t make_query(logic [CH_W-1:0] ch, logic [KIND_W-1:0] kind);
    beat_t b;
    b      = rand_beat();
    b.act  = ACT_QUERY;
    b.ch   = ch;
    b.kind = kind;
    return b;
  endfunction

  // phase 1 is all minimum, phase 2 all maximum, others mixed
  function automatic logic [CFG_DATA_W-1:0] cfg_value(int p, int w);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = (CFG_DATA_W'(1) << w) - 1'b1;
    if (p == 1) v = '0;
    else if (p == 2) v = mask;
    else begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = mask;
        default: v = (CFG_DATA_W'($urandom) & mask) >> $urandom_range(0, w - 1);
      endcase
    end
    // junk above the register width must be dropped
    return v | (CFG_DATA_W'($urandom) & ~mask);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_ZERO_CODE:  zero_code_r  = data[CODE_W-1:0];
      CFG_NEG_OFFSET: neg_offset_r = data[CODE_W-1:0];
      CFG_VOLT_GAIN:  volt_gain_r  = data[GAIN_W-1:0];
      CFG_AMP_GAIN:   amp_gain_r   = data[GAIN_W-1:0];
      CFG_BLANK_LIM:  blank_lim_r  = data[RD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drain everything, then give a trailing round its calibration scan time
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid_i || reading_q.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY_PAD) @(negedge clk_i);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (cur_beat.act == ACT_SAMPLE) store_round(cur_beat);
        else reading_q.push_back(predict_reading(cur_beat));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat   <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_wait = send_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (reading_q.size() == 0) begin
          $error("unexpected result beat: reading %0d, offset_code %0d",
                 reading_o, offset_code_o);
          errors++;
        end else begin
          want = reading_q.pop_front();
          if (reading_o !== want.reading) begin
            $error("reading: expected %0d, actual %0d", want.reading, reading_o);
            errors++;
          end
          if (offset_code_o !== want.code) begin
            $error("offset_code: expected %0d, actual %0d", want.code, offset_code_o);
            errors++;
          end
          if (reading_valid_o !== want.valid) begin
            $error("reading_valid: expected %0d, actual %0d", want.valid, reading_valid_o);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
        // long back-pressure so the input side fills up and stalls
        if (n_results == 30 || n_results == 500) recv_wait = LONG_HOLD;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------- test sequence ----------------

  initial begin
    beat_t b;
    for (int i = 0; i < LANES; i++) lane_lvl[i] = int'($urandom_range(0, 65535));
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(CFG_ZERO_CODE, 24'hABC010);
    cfg_write(CFG_NEG_OFFSET, 24'h5A5040);
    cfg_write(CFG_VOLT_GAIN, 24'h0A0000);
    cfg_write(CFG_AMP_GAIN, 24'h020000);
    cfg_write(CFG_BLANK_LIM, 24'hFF012C);
    cfg_write(CFG_UNUSED_IDX, 24'hFFFFFF);

    @(negedge clk_i);
    // queries on the empty store
    pending_beats.push_back(make_query(4'd0, KIND_POS_VOLT));
    pending_beats.push_back(make_query(4'd5, KIND_AMP_HI));
    // full scale, zero, below the clip floor
    pending_beats.push_back(make_round(16'hFFFF, 1'b0));
    pending_beats.push_back(make_round(16'h0000, 1'b1));
    pending_beats.push_back(make_round(16'h000F, 1'b0));
    b = make_round(16'h8000, 1'b1);
    for (int i = 1; i < LANES; i += 2) b.smp[i] = 16'h7FF0;
    pending_beats.push_back(b);
    pending_beats.push_back(make_query(4'd4, KIND_POS_VOLT));
    pending_beats.push_back(make_query(4'd4, KIND_NEG_VOLT));
    pending_beats.push_back(make_query(4'd4, KIND_AMP_HI));
    pending_beats.push_back(make_query(4'd4, KIND_AMP_LO));
    pending_beats.push_back(make_query(4'd0, KIND_AMP_HI));
    pending_beats.push_back(make_query(4'd15, KIND_AMP_HI));
    pending_beats.push_back(make_query(4'd1, KIND_NEG_VOLT));
    pending_beats.push_back(make_query(4'd12, KIND_NEG_VOLT));
    pending_beats.push_back(make_query(4'd8, KIND_AMP_LO));
    // advance the column pointer and recalibrate on a half-filled window
    for (int i = 0; i < 4; i++) pending_beats.push_back(make_round(16'hFFF0, 1'b1));
    pending_beats.push_back(make_query(4'd7, KIND_AMP_HI));
    pending_beats.push_back(make_query(4'd3, KIND_POS_VOLT));
    pending_beats.push_back(make_query(4'd14, KIND_NEG_VOLT));
    settle();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      cfg_write(CFG_ZERO_CODE, cfg_value(p, CODE_W));
      cfg_write(CFG_NEG_OFFSET, cfg_value(p, CODE_W));
      cfg_write(CFG_VOLT_GAIN, cfg_value(p, GAIN_W));
      cfg_write(CFG_AMP_GAIN, cfg_value(p, GAIN_W));
      cfg_write(CFG_BLANK_LIM, cfg_value(p, RD_W));
      if ($urandom_range(0, 1) == 0) cfg_write(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      for (int i = 0; i < LANES; i++) lane_lvl[i] = int'($urandom_range(0, 65535));
      @(negedge clk_i);
      for (int n = 0; n < PHASE_BEATS; n++) pending_beats.push_back(rand_beat());
      settle();
    end

    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/msa_pkg.sv
design/msa_ram.sv
design/msa_div.sv
design/multichannel_sample_averager.sv
tb/sv/tb.sv
